/* sv/mwd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwd_pkg
// shared types, constants and tables of the multiwave dds with lfo vibrato
// ----------------------------------------------------------------------------
package mwd_pkg;

    localparam int PHASE_BITS  = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int QTR_POINTS  = 64;
    localparam int QTR_SHIFT   = 24;

    localparam logic [31:0] Q30_ONE  = 32'h4000_0000;
    localparam logic [31:0] BEND_ONE = 32'h2000_0000;
    localparam logic [29:0] LN2_Q30  = 30'd744261118;

    // register indexes on the apb port
    localparam logic [2:0] REG_OSC_TW    = 3'd0;
    localparam logic [2:0] REG_LFO_TW    = 3'd1;
    localparam logic [2:0] REG_OSC_SHAPE = 3'd2;
    localparam logic [2:0] REG_LFO_SHAPE = 3'd3;
    localparam logic [2:0] REG_BEND_AMT  = 3'd4;

    typedef enum logic [1:0] {
        SHAPE_SINE   = 2'd0,
        SHAPE_SAW    = 2'd1,
        SHAPE_TRI    = 2'd2,
        SHAPE_SQUARE = 2'd3
    } shape_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LFO,
        ST_EMUL,
        ST_YMUL,
        ST_YREG,
        ST_HMUL,
        ST_HDIV,
        ST_HFIX,
        ST_SCALE,
        ST_RD_BEND,
        ST_RD_OSC,
        ST_OSC,
        ST_OUT
    } seq_state_t;

    typedef logic [SAMPLE_BITS-2:0] qsin_t;
    typedef qsin_t qsin_tab_t [0:QTR_POINTS];

    // quarter-wave sine magnitudes, odd polynomial in q30
    function automatic qsin_tab_t build_qsin();
        qsin_tab_t   tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] x3;
        logic [63:0] x5;
        logic [63:0] x7;
        logic [63:0] x9;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] qs;
        logic [63:0] m;
        for (int i = 0; i <= QTR_POINTS; i++) begin
            x   = 64'(i) << QTR_SHIFT;
            x2  = (x * x) >> 30;
            x3  = (x2 * x) >> 30;
            x5  = (x3 * x2) >> 30;
            x7  = (x5 * x2) >> 30;
            x9  = (x7 * x2) >> 30;
            pos = (64'd1686629713 * x + 64'd85569306 * x5 + 64'd172271 * x9) >> 30;
            neg = (64'd693598669 * x3 + 64'd5026996 * x7) >> 30;
            qs  = (pos > neg) ? pos - neg : 64'd0;
            m   = (qs * (64'd1 << (SAMPLE_BITS - 1)) + 64'd536870912) >> 30;
            if (m > ((64'd1 << (SAMPLE_BITS - 1)) - 64'd1)) begin
                m = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
            end
            tab[i] = m[SAMPLE_BITS-2:0];
        end
        return tab;
    endfunction

    localparam qsin_tab_t QSIN_TAB = build_qsin();

    // floor(2^32 / k), divisor one is handled apart
    function automatic logic [31:0] recip_of(input logic [3:0] k);
        logic [31:0] r;
        case (k)
            4'd2:    r = 32'd2147483648;
            4'd3:    r = 32'd1431655765;
            4'd4:    r = 32'd1073741824;
            4'd5:    r = 32'd858993459;
            4'd6:    r = 32'd715827882;
            4'd7:    r = 32'd613566756;
            4'd8:    r = 32'd536870912;
            4'd9:    r = 32'd477218588;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

/* sv/mwd_wave.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwd_wave
// waveform shaper: sine, saw, triangle or square sample from a phase
// ----------------------------------------------------------------------------
module mwd_wave (
    input  logic [31:0]        phase,
    input  mwd_pkg::shape_t    shape,
    output logic signed [15:0] sample
);

    logic [7:0]         idx;
    logic [6:0]         qk;
    logic [14:0]        mag;
    logic [15:0]        top;
    logic signed [15:0] saw;
    logic [15:0]        av;
    logic signed [17:0] tri_v;

    always_comb begin
        idx   = phase[31:24];
        qk    = idx[6] ? (7'd64 - {1'b0, idx[5:0]}) : {1'b0, idx[5:0]};
        mag   = mwd_pkg::QSIN_TAB[qk];
        top   = phase[31:16];
        saw   = {~top[15], top[14:0]};
        av    = saw[15] ? (16'd0 - 16'(saw)) : 16'(saw);
        tri_v = signed'({1'b0, av, 1'b0}) - 18'sd32768;
        case (shape)
            mwd_pkg::SHAPE_SINE: begin
                sample = idx[7] ? (16'sd0 - signed'({1'b0, mag})) : signed'({1'b0, mag});
            end
            mwd_pkg::SHAPE_SAW: begin
                sample = saw;
            end
            mwd_pkg::SHAPE_TRI: begin
                sample = (tri_v > 18'sd32767) ? 16'sh7fff : tri_v[15:0];
            end
            mwd_pkg::SHAPE_SQUARE: begin
                sample = (phase[31] && (|phase[30:0])) ? 16'sh7fff : 16'sh8000;
            end
            default: begin
                sample = saw;
            end
        endcase
    end

endmodule

/* sv/multiwave_dds_with_lfo_vibrato.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiwave_dds_with_lfo_vibrato
// Two-oscillator sample generator with LFO pitch bend. Every accepted request
// is one sample tick and yields one osc/lfo sample pair. No new request is
// taken until the tick is done: the LFO-times-amount product, the bend
// exponent 2^(lfo*amount) from a nine-step Horner chain, and the main
// oscillator step all run on one shared 32x32 multiplier, and the Horner chain
// takes a multiply, a reciprocal multiply and a remainder fix per step. The
// phases and the bend factor live in a three-entry state memory with a
// registered read and per-entry valid bits, so no clearing pass runs after
// reset. A finished sample waits in the output register while the next
// request is taken. Registers on the APB port: 0x00 osc tuning word,
// 0x04 lfo tuning word, 0x08 osc shape, 0x0c lfo shape, 0x10 bend amount.
// ----------------------------------------------------------------------------
module multiwave_dds_with_lfo_vibrato (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_envelope_done,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_osc_sample,
    output logic signed [15:0] m_lfo_sample,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [1:0] ADDR_OSC  = 2'd0;
    localparam logic [1:0] ADDR_LFO  = 2'd1;
    localparam logic [1:0] ADDR_BEND = 2'd2;

    // configuration
    logic [31:0]        osc_tw_reg;
    logic [31:0]        lfo_tw_reg;
    mwd_pkg::shape_t    osc_shape_reg;
    mwd_pkg::shape_t    lfo_shape_reg;
    logic signed [15:0] bend_amount_reg;
    logic               cfg_wr;

    // sequencer
    mwd_pkg::seq_state_t state_reg, state_next;
    logic               mute_reg, mute_next;
    logic signed [15:0] lfo_sample_reg, lfo_sample_next;
    logic signed [15:0] osc_sample_reg, osc_sample_next;
    logic [63:0]        prod_reg, prod_next;
    logic [29:0]        y_reg, y_next;
    logic [31:0]        acc_reg, acc_next;
    logic [31:0]        a_reg, a_next;
    logic [3:0]         k_reg, k_next;
    logic [2:0]         n_reg, n_next;
    logic               m_valid_reg, m_valid_next;
    logic signed [15:0] m_osc_reg, m_osc_next;
    logic signed [15:0] m_lfo_reg, m_lfo_next;

    // shared multiplier
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_p;

    // state memory
    logic [31:0]        st_mem [0:2];
    logic [2:0]         st_valid_reg;
    logic               rd_en;
    logic [1:0]         rd_addr;
    logic [31:0]        rd_data_reg;
    logic               rd_valid_reg;
    logic [1:0]         rd_addr_reg;
    logic [31:0]        rd_word;
    logic               wr_en;
    logic [1:0]         wr_addr;
    logic [31:0]        wr_data;

    // datapath helpers
    logic [31:0]        ep;
    logic [29:0]        fq;
    logic [31:0]        q0;
    logic [35:0]        q0k;
    logic [35:0]        rem_val;
    logic [31:0]        q;
    logic [31:0]        bend_scaled;
    logic [31:0]        step;
    mwd_pkg::shape_t    shaper_sel;
    logic signed [15:0] wave_sample;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            osc_tw_reg      <= 32'd42852281;
            lfo_tw_reg      <= 32'd42852281;
            osc_shape_reg   <= mwd_pkg::SHAPE_SINE;
            lfo_shape_reg   <= mwd_pkg::SHAPE_SINE;
            bend_amount_reg <= 16'sd0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                mwd_pkg::REG_OSC_TW:    osc_tw_reg      <= pwdata;
                mwd_pkg::REG_LFO_TW:    lfo_tw_reg      <= pwdata;
                mwd_pkg::REG_OSC_SHAPE: osc_shape_reg   <= mwd_pkg::shape_t'(pwdata[1:0]);
                mwd_pkg::REG_LFO_SHAPE: lfo_shape_reg   <= mwd_pkg::shape_t'(pwdata[1:0]);
                mwd_pkg::REG_BEND_AMT:  bend_amount_reg <= signed'(pwdata[15:0]);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            mwd_pkg::REG_OSC_TW:    prdata = osc_tw_reg;
            mwd_pkg::REG_LFO_TW:    prdata = lfo_tw_reg;
            mwd_pkg::REG_OSC_SHAPE: prdata = {30'd0, osc_shape_reg};
            mwd_pkg::REG_LFO_SHAPE: prdata = {30'd0, lfo_shape_reg};
            mwd_pkg::REG_BEND_AMT:  prdata = {16'd0, bend_amount_reg};
            default:                prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // state memory, valid bits stand in for the reset values
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            st_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= (wr_en && (wr_addr == rd_addr)) ? wr_data : st_mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 3'd0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                st_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= (wr_en && (wr_addr == rd_addr)) || st_valid_reg[rd_addr];
            end
        end
    end

    assign rd_word = rd_valid_reg ? rd_data_reg
                   : ((rd_addr_reg == ADDR_BEND) ? mwd_pkg::BEND_ONE : 32'd0);

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    assign shaper_sel = (state_reg == mwd_pkg::ST_LFO) ? lfo_shape_reg : osc_shape_reg;

    mwd_wave u_wave (
        .phase  (rd_word),
        .shape  (shaper_sel),
        .sample (wave_sample)
    );

    always_comb begin
        ep      = prod_reg[31:0] + 32'h4000_0000;
        fq      = {ep[28:0], 1'b0};
        q0      = (k_reg == 4'd1) ? a_reg : prod_reg[63:32];
        q0k     = {4'd0, q0} * {32'd0, k_reg};
        rem_val = {4'd0, a_reg} - q0k;
        q       = (rem_val >= {32'd0, k_reg}) ? q0 + 32'd1 : q0;
        case (n_reg)
            3'd0:    bend_scaled = acc_reg >> 3;
            3'd1:    bend_scaled = acc_reg >> 2;
            3'd2:    bend_scaled = acc_reg >> 1;
            3'd3:    bend_scaled = acc_reg;
            default: bend_scaled = {acc_reg[30:0], 1'b0};
        endcase
        step = (|prod_reg[63:61]) ? 32'hffff_ffff : prod_reg[60:29];
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mwd_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mute_reg       <= mute_next;
        lfo_sample_reg <= lfo_sample_next;
        osc_sample_reg <= osc_sample_next;
        prod_reg       <= prod_next;
        y_reg          <= y_next;
        acc_reg        <= acc_next;
        a_reg          <= a_next;
        k_reg          <= k_next;
        n_reg          <= n_next;
        m_osc_reg      <= m_osc_next;
        m_lfo_reg      <= m_lfo_next;
    end

    always_comb begin
        state_next      = state_reg;
        mute_next       = mute_reg;
        lfo_sample_next = lfo_sample_reg;
        osc_sample_next = osc_sample_reg;
        prod_next       = prod_reg;
        y_next          = y_reg;
        acc_next        = acc_reg;
        a_next          = a_reg;
        k_next          = k_reg;
        n_next          = n_reg;
        m_osc_next      = m_osc_reg;
        m_lfo_next      = m_lfo_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        mul_a           = 32'd0;
        mul_b           = 32'd0;
        rd_en           = 1'b0;
        rd_addr         = ADDR_OSC;
        wr_en           = 1'b0;
        wr_addr         = ADDR_OSC;
        wr_data         = 32'd0;
        s_ready         = 1'b0;

        case (state_reg)
            mwd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    mute_next  = s_envelope_done;
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_LFO;
                    state_next = mwd_pkg::ST_LFO;
                end
            end
            mwd_pkg::ST_LFO: begin
                lfo_sample_next = wave_sample;
                wr_en           = 1'b1;
                wr_addr         = ADDR_LFO;
                wr_data         = rd_word + lfo_tw_reg;
                state_next      = mwd_pkg::ST_EMUL;
            end
            mwd_pkg::ST_EMUL: begin
                mul_a      = {{16{lfo_sample_reg[15]}}, lfo_sample_reg};
                mul_b      = {{16{bend_amount_reg[15]}}, bend_amount_reg};
                prod_next  = mul_p;
                state_next = mwd_pkg::ST_YMUL;
            end
            mwd_pkg::ST_YMUL: begin
                n_next     = ep[31:29];
                mul_a      = {2'd0, fq};
                mul_b      = {2'd0, mwd_pkg::LN2_Q30};
                prod_next  = mul_p;
                state_next = mwd_pkg::ST_YREG;
            end
            mwd_pkg::ST_YREG: begin
                y_next     = prod_reg[59:30];
                acc_next   = mwd_pkg::Q30_ONE;
                k_next     = 4'd9;
                state_next = mwd_pkg::ST_HMUL;
            end
            mwd_pkg::ST_HMUL: begin
                mul_a      = acc_reg;
                mul_b      = {2'd0, y_reg};
                prod_next  = mul_p;
                state_next = mwd_pkg::ST_HDIV;
            end
            mwd_pkg::ST_HDIV: begin
                a_next     = prod_reg[61:30];
                mul_a      = prod_reg[61:30];
                mul_b      = mwd_pkg::recip_of(k_reg);
                prod_next  = mul_p;
                state_next = mwd_pkg::ST_HFIX;
            end
            mwd_pkg::ST_HFIX: begin
                acc_next   = mwd_pkg::Q30_ONE + q;
                k_next     = k_reg - 4'd1;
                state_next = (k_reg == 4'd1) ? mwd_pkg::ST_SCALE : mwd_pkg::ST_HMUL;
            end
            mwd_pkg::ST_SCALE: begin
                wr_en      = 1'b1;
                wr_addr    = ADDR_BEND;
                wr_data    = bend_scaled;
                state_next = mwd_pkg::ST_RD_BEND;
            end
            mwd_pkg::ST_RD_BEND: begin
                rd_en      = 1'b1;
                rd_addr    = ADDR_BEND;
                state_next = mwd_pkg::ST_RD_OSC;
            end
            mwd_pkg::ST_RD_OSC: begin
                mul_a      = osc_tw_reg;
                mul_b      = rd_word;
                prod_next  = mul_p;
                rd_en      = 1'b1;
                rd_addr    = ADDR_OSC;
                state_next = mwd_pkg::ST_OSC;
            end
            mwd_pkg::ST_OSC: begin
                if (mute_reg) begin
                    osc_sample_next = 16'sd0;
                end else begin
                    osc_sample_next = wave_sample;
                    wr_en           = 1'b1;
                    wr_addr         = ADDR_OSC;
                    wr_data         = rd_word + step;
                end
                state_next = mwd_pkg::ST_OUT;
            end
            mwd_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_osc_next   = osc_sample_reg;
                    m_lfo_next   = lfo_sample_reg;
                    state_next   = mwd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mwd_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_osc_sample = m_osc_reg;
    assign m_lfo_sample = m_lfo_reg;

`ifndef SYNTH
    a_one_request_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while a tick is in flight");

    a_octave_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mwd_pkg::ST_SCALE |-> n_reg <= 3'd4)
        else $error("bend octave out of range");

    a_div_one_fix: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mwd_pkg::ST_HFIX |-> rem_val < {31'd0, k_reg, 1'b0})
        else $error("reciprocal quotient off by more than one");

    a_horner_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mwd_pkg::ST_HMUL || state_reg == mwd_pkg::ST_HDIV
         || state_reg == mwd_pkg::ST_HFIX) |-> k_reg != 4'd0)
        else $error("horner step count underflow");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == mwd_pkg::ST_OUT))
        else $error("result raised outside the output state");
`endif

endmodule

/* verif/tb_multiwave_dds_with_lfo_vibrato.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multiwave_dds_with_lfo_vibrato
// Self-checking bench for the vibrato oscillator pair. Sample ticks go in on
// the request channel and tuning, shape and bend registers are set over APB
// between bursts. A bit-true software copy of both oscillators and the bend
// exponent predicts every osc/lfo sample pair. Each returned pair is checked
// in order. Directed ticks cover quarter-cycle phases of every shape, bend
// extremes, step saturation, muting and writes to unused addresses. Random
// bursts follow, most of them under random back-pressure.
// ----------------------------------------------------------------------------
module tb_multiwave_dds_with_lfo_vibrato;

    localparam int CLK_HALF    = 5;
    localparam int TICK_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PHASES = 12;
    localparam int RAND_TICKS  = 50;

    localparam logic [63:0] Q30_UNIT  = 64'd1073741824;
    localparam logic [63:0] LN2_FRAC  = 64'd744261118;
    localparam logic [63:0] SIN_K1    = 64'd1686629713;
    localparam logic [63:0] SIN_K3    = 64'd693598669;
    localparam logic [63:0] SIN_K5    = 64'd85569306;
    localparam logic [63:0] SIN_K7    = 64'd5026996;
    localparam logic [63:0] SIN_K9    = 64'd172271;
    localparam logic [31:0] UNITY_Q29 = 32'h2000_0000;
    localparam logic [31:0] TW_RESET  = 32'd42852281;

    typedef struct packed {
        logic signed [15:0] osc;
        logic signed [15:0] lfo;
    } sample_pair_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_envelope_done;
    logic               m_valid;
    logic               m_ready = 1'b1;
    logic signed [15:0] m_osc_sample;
    logic signed [15:0] m_lfo_sample;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // predictor registers and state
    logic [31:0]        osc_tw;
    logic [31:0]        lfo_tw;
    mwd_pkg::shape_t    osc_shp;
    mwd_pkg::shape_t    lfo_shp;
    logic signed [15:0] bend_amt;
    logic [31:0]        osc_ph;
    logic [31:0]        lfo_ph;
    logic [31:0]        bend_q329;

    sample_pair_t expected_samples[$];
    sample_pair_t want;

    int  cycle_count   = 0;
    int  ticks_sent    = 0;
    int  pairs_checked = 0;
    int  reg_writes    = 0;
    int  error_count   = 0;
    int  stall_left    = 0;
    bit  idle_on       = 1'b0;

    multiwave_dds_with_lfo_vibrato dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_envelope_done (s_envelope_done),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_osc_sample    (m_osc_sample),
        .m_lfo_sample    (m_lfo_sample),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_multiwave_dds_with_lfo_vibrato failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic logic signed [15:0] shape_sample(input logic [31:0] ph,
                                                        input mwd_pkg::shape_t shp);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] x3;
        logic [63:0] x5;
        logic [63:0] x7;
        logic [63:0] x9;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] q;
        logic [63:0] m;
        int          v;
        case (shp)
            mwd_pkg::SHAPE_SINE: begin
                x = 64'(ph[29:24]) << 24;
                if (ph[30]) begin
                    x = Q30_UNIT - x;
                end
                x2  = (x * x) >> 30;
                x3  = (x2 * x) >> 30;
                x5  = (x3 * x2) >> 30;
                x7  = (x5 * x2) >> 30;
                x9  = (x7 * x2) >> 30;
                pos = (SIN_K1 * x + SIN_K5 * x5 + SIN_K9 * x9) >> 30;
                neg = (SIN_K3 * x3 + SIN_K7 * x7) >> 30;
                q   = (pos > neg) ? pos - neg : 64'd0;
                m   = (q * 64'd32768 + (Q30_UNIT >> 1)) >> 30;
                if (m > 64'd32767) begin
                    m = 64'd32767;
                end
                return ph[31] ? -(16'(m)) : 16'(m);
            end
            mwd_pkg::SHAPE_SAW: begin
                v = int'(ph[31:16]) - 32768;
                return 16'(v);
            end
            mwd_pkg::SHAPE_TRI: begin
                v = int'(ph[31:16]) - 32768;
                if (v < 0) begin
                    v = -v;
                end
                v = 2 * v - 32768;
                if (v > 32767) begin
                    v = 32767;
                end
                return 16'(v);
            end
            default: begin
                return (ph > 32'h8000_0000) ? 16'sh7FFF : 16'sh8000;
            end
        endcase
    endfunction

    // 2^(lfo * amount) in unsigned q3.29
    function automatic logic [31:0] pitch_bend(input logic signed [15:0] lfo,
                                               input logic signed [15:0] amt);
        longint      e;
        logic [63:0] ep;
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] y;
        logic [63:0] acc;
        e   = longint'(lfo) * longint'(amt);
        ep  = e + 64'sd1073741824;
        n   = ep >> 29;
        f   = ep & 64'h1FFF_FFFF;
        y   = ((f << 1) * LN2_FRAC) >> 30;
        acc = Q30_UNIT;
        for (int k = 9; k >= 1; k--) begin
            acc = Q30_UNIT + ((acc * y) >> 30) / 64'(k);
        end
        if (n > 64'd4) begin
            n = 64'd4;
        end
        if (n >= 64'd3) begin
            acc = acc << (n - 64'd3);
        end else begin
            acc = acc >> (64'd3 - n);
        end
        return acc[31:0];
    endfunction

    // one sample tick: lfo first, then bend, then the main oscillator
    function automatic sample_pair_t next_samples(input logic muted);
        sample_pair_t r;
        logic [63:0]  step;
        r.lfo     = shape_sample(lfo_ph, lfo_shp);
        lfo_ph    = lfo_ph + lfo_tw;
        bend_q329 = pitch_bend(r.lfo, bend_amt);
        r.osc     = '0;
        if (!muted) begin
            step = (64'(osc_tw) * 64'(bend_q329)) >> 29;
            if (step > 64'hFFFF_FFFF) begin
                step = 64'hFFFF_FFFF;
            end
            r.osc  = shape_sample(osc_ph, osc_shp);
            osc_ph = osc_ph + step[31:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_samples.size() == 0) begin
                $error("sample pair with no request pending: osc %0d lfo %0d",
                       m_osc_sample, m_lfo_sample);
                error_count++;
            end else begin
                want = expected_samples.pop_front();
                pairs_checked++;
                if (m_osc_sample !== want.osc) begin
                    $error("osc_sample mismatch: expected %0d, got %0d",
                           want.osc, m_osc_sample);
                    error_count++;
                end
                if (m_lfo_sample !== want.lfo) begin
                    $error("lfo_sample mismatch: expected %0d, got %0d",
                           want.lfo, m_lfo_sample);
                    error_count++;
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [4:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
    endtask

    task automatic set_reg(input int idx, input logic [31:0] value);
        apb_write(5'(idx * 4), value);
        case (idx)
            mwd_pkg::REG_OSC_TW:    osc_tw   = value;
            mwd_pkg::REG_LFO_TW:    lfo_tw   = value;
            mwd_pkg::REG_OSC_SHAPE: osc_shp  = mwd_pkg::shape_t'(value[1:0]);
            mwd_pkg::REG_LFO_SHAPE: lfo_shp  = mwd_pkg::shape_t'(value[1:0]);
            mwd_pkg::REG_BEND_AMT:  bend_amt = value[15:0];
            default: ;
        endcase
    endtask

    task automatic send_tick(input logic env);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_envelope_done <= env;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_samples.push_back(next_samples(env));
        ticks_sent++;
    endtask

    task automatic drain_samples();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (TICK_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_tuning();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(0, 32'h0800_0000);
            3:       return 32'h8000_0000 + $urandom_range(0, 255) - 128;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_bend();
        case ($urandom_range(0, 4))
            0:       return 32'h0000_8000;
            1:       return 32'h0000_7FFF;
            2:       return 32'd0;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        repeat (3) send_tick(1'b0);
    endtask

    // unity bend makes the osc step equal the tuning word, so both
    // phases can be brought back to zero in one tick
    task automatic test_shape_quarters();
        drain_samples();
        set_reg(mwd_pkg::REG_OSC_TW, -osc_ph);
        set_reg(mwd_pkg::REG_LFO_TW, -lfo_ph);
        send_tick(1'b0);
        drain_samples();
        set_reg(mwd_pkg::REG_OSC_TW, 32'h4000_0000);
        set_reg(mwd_pkg::REG_LFO_TW, 32'h4000_0000);
        for (int s = 0; s < 4; s++) begin
            drain_samples();
            set_reg(mwd_pkg::REG_OSC_SHAPE, 32'(s));
            set_reg(mwd_pkg::REG_LFO_SHAPE, 32'(3 - s));
            repeat (3) send_tick(1'b0);
        end
    endtask

    // square lfo at full swing with extreme bend, step clamps at all ones
    task automatic test_bend_saturation();
        drain_samples();
        set_reg(mwd_pkg::REG_LFO_SHAPE, 32'(mwd_pkg::SHAPE_SQUARE));
        set_reg(mwd_pkg::REG_OSC_SHAPE, 32'(mwd_pkg::SHAPE_SAW));
        set_reg(mwd_pkg::REG_OSC_TW, 32'hFFFF_FFFF);
        set_reg(mwd_pkg::REG_BEND_AMT, 32'h0000_8000);
        repeat (2) send_tick(1'b0);
        drain_samples();
        set_reg(mwd_pkg::REG_BEND_AMT, 32'h0000_7FFF);
        repeat (2) send_tick(1'b0);
    endtask

    task automatic test_envelope_mute();
        drain_samples();
        set_reg(mwd_pkg::REG_OSC_SHAPE, 32'(mwd_pkg::SHAPE_TRI));
        repeat (2) send_tick(1'b1);
        send_tick(1'b0);
        drain_samples();
        set_reg(mwd_pkg::REG_OSC_TW, 32'd0);
        send_tick(1'b0);
    endtask

    // writes past the last register must leave everything alone
    task automatic test_unused_registers();
        drain_samples();
        for (int k = 1; k <= 3; k++) begin
            set_reg(int'(mwd_pkg::REG_BEND_AMT) + k, $urandom);
        end
        send_tick(1'b0);
    endtask

    task automatic test_random_ticks();
        for (int p = 0; p < RAND_PHASES; p++) begin
            drain_samples();
            idle_on = (p < RAND_PHASES - 2) && (p % 3 != 2);
            set_reg(mwd_pkg::REG_OSC_TW, pick_tuning());
            set_reg(mwd_pkg::REG_LFO_TW, pick_tuning());
            set_reg(mwd_pkg::REG_OSC_SHAPE, $urandom_range(0, 3));
            set_reg(mwd_pkg::REG_LFO_SHAPE, $urandom_range(0, 3));
            set_reg(mwd_pkg::REG_BEND_AMT, pick_bend());
            for (int i = 0; i < RAND_TICKS; i++) begin
                send_tick($urandom_range(0, 7) == 0);
            end
        end
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_envelope_done = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        osc_tw          = TW_RESET;
        lfo_tw          = TW_RESET;
        osc_shp         = mwd_pkg::SHAPE_SINE;
        lfo_shp         = mwd_pkg::SHAPE_SINE;
        bend_amt        = '0;
        osc_ph          = '0;
        lfo_ph          = '0;
        bend_q329       = UNITY_Q29;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        idle_on = 1'b1;
        test_reset_defaults();
        test_shape_quarters();
        test_bend_saturation();
        test_envelope_mute();
        test_unused_registers();
        test_random_ticks();
        drain_samples();

        $display("%0d sample ticks sent, %0d sample pairs checked, %0d register writes",
                 ticks_sent, pairs_checked, reg_writes);
        $display("all shapes on both oscillators, bend extremes, step clamp and muting");
        if (error_count == 0) begin
            $display("tb_multiwave_dds_with_lfo_vibrato passed");
        end else begin
            $display("tb_multiwave_dds_with_lfo_vibrato failed");
        end
        $finish;
    end

endmodule
